// File: hdl/bmt_pkg.sv
// ============================================================================
// bmt_pkg
// Shared types and constants for the breakpoint match table.
// ============================================================================
package bmt_pkg;

  // Field widths of the item channels
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned STATUS_W = 2;

  // Defaults for the top-level parameters
  localparam int unsigned ENTRIES_DEF    = 8;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Mask applied to added addresses when even alignment is on
  localparam logic [ADDR_W-1:0] EVEN_MASK = 32'hffff_fffe;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD       = 3'd0,
    ACT_CLEAR     = 3'd1,
    ACT_TOGGLE    = 3'd2,
    ACT_HIT       = 3'd3,
    ACT_CLEAR_ALL = 3'd4
  } bmt_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } bmt_status_e;

  // Operation broadcast to every cell
  typedef struct packed {
    logic              en;
    bmt_action_e       action;
    logic [ADDR_W-1:0] addr;
  } bmt_op_t;

  // Priority chain handed from cell to cell, lowest index first
  typedef struct packed {
    logic sel_seen;    // a lower cell holds a valid matching address
    logic sel_active;  // that selected cell is active
    logic free_seen;   // a lower cell is free
    logic any_valid;   // a lower cell is valid
  } bmt_chain_t;

endpackage

// File: hdl/bmt_if.sv
// ============================================================================
// bmt_if
// Valid/ready channels for requests, responses and the configuration write.
// ============================================================================
interface bmt_req_if;
  import bmt_pkg::*;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   address;
  logic [CNT_W-1:0]    pass_count;

  modport source (output valid, action, address, pass_count, input ready);
  modport sink   (input valid, action, address, pass_count, output ready);
endinterface

interface bmt_rsp_if;
  import bmt_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                matched;
  logic                removed;
  logic [CNT_W-1:0]    count_left;

  modport source (output valid, status, matched, removed, count_left, input ready);
  modport sink   (input valid, status, matched, removed, count_left, output ready);
endinterface

interface bmt_cfg_if;
  logic valid;
  logic ready;
  logic align_even;

  modport source (output valid, align_even, input ready);
  modport sink   (input valid, align_even, output ready);
endinterface

// File: hdl/breakpoint_match_table_core.sv
// The response item is registered and shows in the cycle after acceptance.
// Throughput: one item per cycle; the chain of slot cells resolves the
//   lowest matching and lowest free slot within the accepting cycle.
// A stalled response holds; a new item is taken as the response drains.
// Reset (rst_ni low, asynchronous): table empty, alignment off, no response.
// ============================================================================
// breakpoint_match_table_core
// Breakpoint table built as a row of slot cells joined by a priority chain,
// with a registered response stage and a one-bit configuration register.
// ============================================================================
module breakpoint_match_table_core
  import bmt_pkg::*;
#(
  parameter int unsigned Entries   = ENTRIES_DEF,
  parameter int unsigned CountBits = COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmt_cfg_if.sink   cfg_i,
  bmt_req_if.sink   req_i,
  bmt_rsp_if.source rsp_o
);

  logic                 align_q;
  logic                 accept;
  bmt_action_e          action;
  bmt_op_t              op;
  logic [CountBits-1:0] count_sat;
  logic                 add_reject;
  bmt_chain_t           chain [Entries+1];
  logic [Entries-1:0]   cell_removed;
  logic [CountBits-1:0] cell_left [Entries];
  logic [CountBits-1:0] left_sel;
  logic [CNT_W-1:0]     left_ext;
  logic                 any_removed;

  logic                 rsp_valid_q;
  bmt_status_e          status_q, status_d;
  logic                 matched_q, matched_d;
  logic                 removed_q, removed_d;
  logic [CNT_W-1:0]     left_q, left_d;

  // Configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= 1'b0;
    end else if (cfg_i.valid) begin
      align_q <= cfg_i.align_even;
    end
  end

  // Take a new item whenever the response stage is free or draining
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign action      = bmt_action_e'(req_i.action);

  always_comb begin
    op.en     = accept;
    op.action = action;
    op.addr   = ((action == ACT_ADD) && align_q) ? (req_i.address & EVEN_MASK)
                                                 : req_i.address;
  end

  // Saturate the pass count to the slot count width
  generate
    if (CountBits >= CNT_W) begin : g_cnt_wide
      assign count_sat = CountBits'(req_i.pass_count);
      assign left_ext  = left_sel[CNT_W-1:0];
    end else begin : g_cnt_narrow
      assign count_sat = ((req_i.pass_count >> CountBits) != '0) ? '1
                         : req_i.pass_count[CountBits-1:0];
      assign left_ext  = CNT_W'(left_sel);
    end
  endgenerate

  // Row of slot cells
  assign chain[0]   = '0;
  assign add_reject = chain[Entries].sel_active;

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    bmt_cell #(
      .CountBits (CountBits)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (op),
      .add_count_i  (count_sat),
      .add_reject_i (add_reject),
      .chain_i      (chain[i]),
      .chain_o      (chain[i+1]),
      .removed_o    (cell_removed[i]),
      .left_o       (cell_left[i])
    );
  end

  // At most one cell reports a count, so merge by OR
  always_comb begin
    left_sel = '0;
    for (int i = 0; i < Entries; i++) begin
      left_sel = left_sel | cell_left[i];
    end
  end

  assign any_removed = |cell_removed;

  // Build the response item
  always_comb begin
    status_d  = ST_DONE;
    matched_d = 1'b0;
    removed_d = 1'b0;
    left_d    = '0;
    case (action)
      ACT_ADD: begin
        if (add_reject) begin
          status_d = ST_PRESENT;
        end else if (!chain[Entries].free_seen) begin
          status_d = ST_FULL;
        end else begin
          left_d = (CountBits >= CNT_W) ? req_i.pass_count : CNT_W'(count_sat);
        end
      end
      ACT_CLEAR: begin
        status_d  = chain[Entries].sel_active ? ST_DONE : ST_MISSING;
        removed_d = any_removed;
      end
      ACT_TOGGLE: begin
        status_d = chain[Entries].sel_seen ? ST_DONE : ST_MISSING;
        left_d   = left_ext;
      end
      ACT_HIT: begin
        status_d  = chain[Entries].sel_active ? ST_DONE : ST_MISSING;
        matched_d = chain[Entries].sel_active;
        removed_d = any_removed;
        left_d    = left_ext;
      end
      ACT_CLEAR_ALL: begin
        removed_d = chain[Entries].any_valid;
      end
      default: begin
      end
    endcase
  end

  // Response stage: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      matched_q <= matched_d;
      removed_q <= removed_d;
      left_q    <= left_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.matched    = matched_q;
  assign rsp_o.removed    = removed_q;
  assign rsp_o.count_left = left_q;

endmodule

// File: hdl/bmt_cell.sv
// ============================================================================
// bmt_cell
// One breakpoint slot: address, pass count, active and valid marks, plus its
// link in the lowest-index priority chain.
// ============================================================================
module bmt_cell
  import bmt_pkg::*;
#(
  parameter int unsigned CountBits = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmt_op_t              op_i,
  input  logic [CountBits-1:0] add_count_i,
  input  logic                 add_reject_i,
  input  bmt_chain_t           chain_i,
  output bmt_chain_t           chain_o,
  output logic                 removed_o,
  output logic [CountBits-1:0] left_o
);

  logic                 valid_q, valid_d;
  logic                 active_q, active_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 hit;
  logic                 is_sel;
  logic [CountBits-1:0] count_dec;

  // Compare locally and extend the chain
  assign hit    = valid_q && (addr_q == op_i.addr);
  assign is_sel = hit && !chain_i.sel_seen;

  always_comb begin
    chain_o.sel_seen   = chain_i.sel_seen | hit;
    chain_o.sel_active = chain_i.sel_seen ? chain_i.sel_active : (hit & active_q);
    chain_o.free_seen  = chain_i.free_seen | ~valid_q;
    chain_o.any_valid  = chain_i.any_valid | valid_q;
  end

  assign count_dec = count_q - CountBits'(1);

  // Work out the slot update and what it reports
  always_comb begin
    valid_d   = valid_q;
    active_d  = active_q;
    addr_d    = addr_q;
    count_d   = count_q;
    removed_o = 1'b0;
    left_o    = '0;
    case (op_i.action)
      ACT_ADD: begin
        // first free slot takes the entry unless the lowest matching slot is active
        if (!add_reject_i && !chain_i.free_seen && !valid_q) begin
          valid_d  = 1'b1;
          active_d = 1'b1;
          addr_d   = op_i.addr;
          count_d  = add_count_i;
        end
      end
      ACT_CLEAR: begin
        if (is_sel && active_q) begin
          valid_d   = 1'b0;
          active_d  = 1'b0;
          removed_o = 1'b1;
        end
      end
      ACT_TOGGLE: begin
        if (is_sel) begin
          active_d = ~active_q;
          left_o   = count_q;
        end
      end
      ACT_HIT: begin
        // zero count is permanent; otherwise count down and drop at zero
        if (is_sel && active_q && (count_q != '0)) begin
          count_d = count_dec;
          if (count_dec == '0) begin
            valid_d   = 1'b0;
            active_d  = 1'b0;
            removed_o = 1'b1;
          end else begin
            left_o = count_dec;
          end
        end
      end
      ACT_CLEAR_ALL: begin
        valid_d   = 1'b0;
        active_d  = 1'b0;
        removed_o = valid_q;
      end
      default: begin
      end
    endcase
  end

  // Clear marks under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      active_q <= 1'b0;
    end else if (op_i.en) begin
      valid_q  <= valid_d;
      active_q <= active_d;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      addr_q  <= addr_d;
      count_q <= count_d;
    end
  end

endmodule

// File: hdl/bmt_checker.sv
// ============================================================================
// bmt_checker
// Port-level checks on the breakpoint match table, bound to the top level.
// ============================================================================
module bmt_checker
  import bmt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic                rsp_matched_i,
  input logic                rsp_removed_i,
  input logic [CNT_W-1:0]    rsp_count_left_i
);

  // Hold a stalled response item
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
                                    && $stable(rsp_count_left_i))
    else $error("stalled response item changed");

  // Every accepted item gives a response in the next cycle
  a_req_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("accepted item gave no response");

  // Take no item while a response is stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("item taken over a stalled response");

  // A match is always a successful step
  a_match_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_matched_i |-> rsp_status_i == ST_DONE)
    else $error("match reported with failing status");

  // A freed slot leaves no count behind
  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_removed_i |-> rsp_count_left_i == '0
                                     && rsp_status_i == ST_DONE)
    else $error("removal reported with a count or failing status");

endmodule

bind breakpoint_match_table_core bmt_checker u_bmt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_matched_i    (rsp_o.matched),
  .rsp_removed_i    (rsp_o.removed),
  .rsp_count_left_i (rsp_o.count_left)
);
